[src/tehr_pkg.sv]
// Types, constants and the control program of the timestamped event history ring.
package tehr_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned MAX_RESULTS = 32;
	localparam int unsigned RCNT_W = 6;
	localparam logic [RCNT_W-1:0] RCNT_MAX = 6'd32;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic REG_INITIAL_VALUE = 1'b0;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_RANGE = 2'd2;
	localparam logic [1:0] FUNC_ROLLBACK = 2'd3;

	typedef struct packed {
		logic [1:0]        func;
		logic [DATA_W-1:0] time_a;
		logic [DATA_W-1:0] time_b;
		logic [DATA_W-1:0] event_value;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] result_value;
		logic              hit;
		logic              last;
		logic              overflow_warning;
		logic [DATA_W-1:0] latest_time;
	} out_item_t;

	typedef logic [3:0] upc_t;

	localparam upc_t UPC_IDLE = 4'd0;
	localparam upc_t UPC_INS_DISC = 4'd1;
	localparam upc_t UPC_INS_WRITE = 4'd2;
	localparam upc_t UPC_RB_DISC = 4'd3;
	localparam upc_t UPC_RB_EMIT = 4'd4;
	localparam upc_t UPC_LK_WALK = 4'd5;
	localparam upc_t UPC_LK_FIX = 4'd6;
	localparam upc_t UPC_LK_EMIT = 4'd7;
	localparam upc_t UPC_RG_WALK = 4'd8;
	localparam upc_t UPC_RG_EMIT = 4'd9;

	typedef enum logic [3:0] {
		ACT_LOAD,
		ACT_DISCARD,
		ACT_INSERT,
		ACT_EMIT_RB,
		ACT_LK_WALK,
		ACT_LK_FIX,
		ACT_EMIT_LK,
		ACT_RG_WALK,
		ACT_EMIT_RG
	} act_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_GOTO,
		SEQ_LOOP,
		SEQ_DISPATCH
	} seq_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_IN,
		HOLD_OUT
	} hold_t;

	typedef struct packed {
		act_t  act;
		hold_t hold;
		seq_t  seq;
		upc_t  target;
	} uc_word_t;

	function automatic uc_word_t uc_rom(input upc_t pc);
		uc_word_t w;
		unique case (pc)
			UPC_IDLE:      w = '{act: ACT_LOAD, hold: HOLD_IN, seq: SEQ_DISPATCH, target: UPC_IDLE};
			UPC_INS_DISC:  w = '{act: ACT_DISCARD, hold: HOLD_NONE, seq: SEQ_LOOP, target: UPC_IDLE};
			UPC_INS_WRITE: w = '{act: ACT_INSERT, hold: HOLD_OUT, seq: SEQ_GOTO, target: UPC_IDLE};
			UPC_RB_DISC:   w = '{act: ACT_DISCARD, hold: HOLD_NONE, seq: SEQ_LOOP, target: UPC_IDLE};
			UPC_RB_EMIT:   w = '{act: ACT_EMIT_RB, hold: HOLD_OUT, seq: SEQ_GOTO, target: UPC_IDLE};
			UPC_LK_WALK:   w = '{act: ACT_LK_WALK, hold: HOLD_NONE, seq: SEQ_LOOP, target: UPC_IDLE};
			UPC_LK_FIX:    w = '{act: ACT_LK_FIX, hold: HOLD_NONE, seq: SEQ_NEXT, target: UPC_IDLE};
			UPC_LK_EMIT:   w = '{act: ACT_EMIT_LK, hold: HOLD_OUT, seq: SEQ_GOTO, target: UPC_IDLE};
			UPC_RG_WALK:   w = '{act: ACT_RG_WALK, hold: HOLD_NONE, seq: SEQ_LOOP, target: UPC_IDLE};
			UPC_RG_EMIT:   w = '{act: ACT_EMIT_RG, hold: HOLD_OUT, seq: SEQ_GOTO, target: UPC_IDLE};
			default:       w = '{act: ACT_LOAD, hold: HOLD_IN, seq: SEQ_DISPATCH, target: UPC_IDLE};
		endcase
		return w;
	endfunction

	function automatic upc_t uc_entry(input logic [1:0] func);
		upc_t pc;
		unique case (func)
			FUNC_INSERT:   pc = UPC_INS_DISC;
			FUNC_LOOKUP:   pc = UPC_LK_WALK;
			FUNC_RANGE:    pc = UPC_RG_WALK;
			FUNC_ROLLBACK: pc = UPC_RB_DISC;
			default:       pc = UPC_IDLE;
		endcase
		return pc;
	endfunction

endpackage

[src/tehr_if.sv]
// Valid/ready channel interfaces for request and result transactions.
interface tehr_req_if;
	logic                 valid;
	logic                 ready;
	tehr_pkg::in_item_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tehr_rsp_if;
	logic                 valid;
	logic                 ready;
	tehr_pkg::out_item_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[src/timestamped_event_history_ring_top.sv]
// Top level of the timestamped event history ring with its microcoded sequencer.
// The req channel takes one transaction per operation: insert, lookup, range query or
// rollback, chosen by func. The rsp channel returns one result transaction per
// operation, or for a range query one per matching entry up to RCNT_MAX (a single
// result with hit low if none match), the final one marked by last. The APB port
// holds initial_value; a write to it also clears the ring to a single entry at time
// zero. The user must make writes only while no operation is in flight; the block
// does not enforce it. One operation is in flight at a time; req.ready is high only
// while the sequencer waits for work. An insert or rollback steps back over each
// discarded entry, and a lookup or range query walks back through the ring; each
// reads one entry per cycle through the single read port of the entry memory, a
// range query only while the output register does not stall it. Results sit in an
// output register; while the receiver stalls, the sequencer holds at the step that
// produces the next result and resumes when the register frees. Reset leaves one
// valid entry at time zero holding initial_value, which reset sets to zero; no
// clearing pass is needed since valid bits live in flip-flops.
module timestamped_event_history_ring_top #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tehr_req_if.sink                            req,
	tehr_rsp_if.source                          rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tehr_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [tehr_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [tehr_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] OVF_IDX = PTR_W'(DEPTH - 2);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] p);
		return (p == '0) ? LAST_IDX : PTR_W'(p - 1'b1);
	endfunction

	function automatic logic [PTR_W-1:0] step_fwd(input logic [PTR_W-1:0] p);
		return (p == LAST_IDX) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	logic [tehr_pkg::DATA_W-1:0] mem_time [DEPTH];
	logic [tehr_pkg::DATA_W-1:0] mem_data [DEPTH];
	logic [tehr_pkg::DATA_W-1:0] rd_time_q, rd_data_q;
	logic                        mem_we;
	logic [PTR_W-1:0]            mem_waddr;

	tehr_pkg::upc_t      upc_q, upc_d;
	tehr_pkg::uc_word_t  uc;
	logic                hold, go, cont;

	logic [PTR_W-1:0]    ptr_q, ptr_d, cur_q, cur_d, start_q, start_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [tehr_pkg::RCNT_W-1:0] rcnt_q, rcnt_d;
	logic                pend_v_q, pend_v_d;
	logic [tehr_pkg::DATA_W-1:0] pend_q, pend_d;
	logic [tehr_pkg::DATA_W-1:0] latest_q, latest_d;
	logic [DEPTH-1:0]    valid_q, valid_d;
	logic                zinit_q, zinit_d;
	logic [tehr_pkg::DATA_W-1:0] init_q;

	logic [tehr_pkg::DATA_W-1:0] ta_q, tb_q, ev_q;
	logic                        in_load;

	logic                 out_v_q, out_v_d, out_free, load_out;
	tehr_pkg::out_item_t  out_q, out_pl;

	logic                        eff_valid, eff_zero;
	logic [tehr_pkg::DATA_W-1:0] eff_time, eff_data;
	logic                        disc_step, lk_step, lk_wrap, rg_step, rg_match, rg_stall;
	logic                        ins_hit;
	logic [PTR_W-1:0]            ins_p, back_cur;
	logic                        cfg_wr, cfg_sel;

	assign pready = 1'b1;
	assign cfg_sel = (paddr[2] == tehr_pkg::REG_INITIAL_VALUE);
	assign cfg_wr = psel && penable && pwrite && cfg_sel;
	assign prdata = cfg_sel ? init_q : '0;

	assign eff_valid = valid_q[cur_q];
	assign eff_zero = zinit_q && (cur_q == '0);
	assign eff_time = (!eff_valid || eff_zero) ? '0 : rd_time_q;
	assign eff_data = !eff_valid ? '0 : (eff_zero ? init_q : rd_data_q);

	assign back_cur = step_back(cur_q);
	assign disc_step = eff_valid && (eff_time > ta_q) && (cnt_q < DEPTH_CNT);
	assign lk_step = eff_valid && (ta_q < eff_time);
	assign lk_wrap = (back_cur == start_q);
	assign rg_step = eff_valid && (eff_time != '0) && (ta_q <= eff_time) && (cnt_q < DEPTH_CNT);
	assign rg_match = rg_step && (eff_time <= tb_q) && (rcnt_q < tehr_pkg::RCNT_MAX);
	assign rg_stall = (uc.act == tehr_pkg::ACT_RG_WALK) && rg_match && pend_v_q && !out_free;
	assign ins_hit = eff_valid && (eff_time == ta_q);
	assign ins_p = ins_hit ? cur_q : step_fwd(cur_q);

	assign out_free = !out_v_q || rsp.ready;
	assign req.ready = (upc_q == tehr_pkg::UPC_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	assign uc = tehr_pkg::uc_rom(upc_q);

	always_comb begin
		unique case (uc.act)
			tehr_pkg::ACT_DISCARD: cont = disc_step;
			tehr_pkg::ACT_LK_WALK: cont = lk_step && !lk_wrap;
			tehr_pkg::ACT_RG_WALK: cont = rg_step;
			default:               cont = 1'b0;
		endcase
	end

	always_comb begin
		unique case (uc.hold)
			tehr_pkg::HOLD_IN:  hold = !req.valid;
			tehr_pkg::HOLD_OUT: hold = !out_free;
			default:            hold = rg_stall;
		endcase
		go = !hold;
		upc_d = upc_q;
		if (go) begin
			unique case (uc.seq)
				tehr_pkg::SEQ_NEXT:     upc_d = tehr_pkg::upc_t'(upc_q + 1'b1);
				tehr_pkg::SEQ_GOTO:     upc_d = uc.target;
				tehr_pkg::SEQ_LOOP:     upc_d = cont ? upc_q : tehr_pkg::upc_t'(upc_q + 1'b1);
				tehr_pkg::SEQ_DISPATCH: upc_d = tehr_pkg::uc_entry(req.data.func);
				default:                upc_d = tehr_pkg::UPC_IDLE;
			endcase
		end
	end

	always_comb begin
		ptr_d = ptr_q;
		cur_d = cur_q;
		start_d = start_q;
		cnt_d = cnt_q;
		rcnt_d = rcnt_q;
		pend_v_d = pend_v_q;
		pend_d = pend_q;
		latest_d = latest_q;
		valid_d = valid_q;
		zinit_d = zinit_q;
		mem_we = 1'b0;
		mem_waddr = ins_p;
		in_load = 1'b0;
		load_out = 1'b0;
		out_pl = '{result_value: '0, hit: 1'b0, last: 1'b1, overflow_warning: 1'b0,
			latest_time: latest_q};
		if (uc.act == tehr_pkg::ACT_LOAD) begin
			cur_d = ptr_q;
		end
		if (go) begin
			unique case (uc.act)
				tehr_pkg::ACT_LOAD: begin
					in_load = 1'b1;
					cur_d = ptr_q;
					start_d = ptr_q;
					cnt_d = '0;
					rcnt_d = '0;
					pend_v_d = 1'b0;
				end
				tehr_pkg::ACT_DISCARD: begin
					if (disc_step) begin
						valid_d[cur_q] = 1'b0;
						cur_d = back_cur;
						ptr_d = back_cur;
						cnt_d = CNT_W'(cnt_q + 1'b1);
					end else begin
						latest_d = eff_time;
					end
				end
				tehr_pkg::ACT_INSERT: begin
					mem_we = 1'b1;
					valid_d[ins_p] = 1'b1;
					ptr_d = ins_p;
					if (ins_p == '0) begin
						zinit_d = 1'b0;
					end
					latest_d = ta_q;
					load_out = 1'b1;
					out_pl = '{result_value: '0, hit: 1'b0, last: 1'b1,
						overflow_warning: (ins_p >= OVF_IDX), latest_time: ta_q};
				end
				tehr_pkg::ACT_EMIT_RB, tehr_pkg::ACT_EMIT_LK: begin
					load_out = 1'b1;
					out_pl = '{result_value: eff_data, hit: eff_valid, last: 1'b1,
						overflow_warning: 1'b0, latest_time: latest_q};
				end
				tehr_pkg::ACT_LK_WALK: begin
					if (lk_step) begin
						cur_d = lk_wrap ? '0 : back_cur;
					end
				end
				tehr_pkg::ACT_LK_FIX: begin
					cur_d = eff_valid ? cur_q : step_fwd(cur_q);
				end
				tehr_pkg::ACT_RG_WALK: begin
					if (rg_step) begin
						cur_d = back_cur;
						cnt_d = CNT_W'(cnt_q + 1'b1);
						if (rg_match) begin
							pend_d = eff_data;
							pend_v_d = 1'b1;
							rcnt_d = tehr_pkg::RCNT_W'(rcnt_q + 1'b1);
							if (pend_v_q) begin
								load_out = 1'b1;
								out_pl = '{result_value: pend_q, hit: 1'b1, last: 1'b0,
									overflow_warning: 1'b0, latest_time: latest_q};
							end
						end
					end
				end
				tehr_pkg::ACT_EMIT_RG: begin
					load_out = 1'b1;
					out_pl = '{result_value: pend_v_q ? pend_q : '0, hit: pend_v_q, last: 1'b1,
						overflow_warning: 1'b0, latest_time: latest_q};
				end
				default: begin
				end
			endcase
		end
		if (cfg_wr && pready) begin
			valid_d = DEPTH'(1);
			ptr_d = '0;
			zinit_d = 1'b1;
			latest_d = '0;
		end
		out_v_d = load_out ? 1'b1 : (out_v_q && !rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= tehr_pkg::UPC_IDLE;
			ptr_q <= '0;
			cur_q <= '0;
			start_q <= '0;
			cnt_q <= '0;
			rcnt_q <= '0;
			pend_v_q <= 1'b0;
			latest_q <= '0;
			valid_q <= DEPTH'(1);
			zinit_q <= 1'b1;
			init_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			ptr_q <= ptr_d;
			cur_q <= cur_d;
			start_q <= start_d;
			cnt_q <= cnt_d;
			rcnt_q <= rcnt_d;
			pend_v_q <= pend_v_d;
			latest_q <= latest_d;
			valid_q <= valid_d;
			zinit_q <= zinit_d;
			if (cfg_wr) begin
				init_q <= pwdata;
			end
			out_v_q <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			ta_q <= req.data.time_a;
			tb_q <= req.data.time_b;
			ev_q <= req.data.event_value;
		end
		pend_q <= pend_d;
		if (load_out) begin
			out_q <= out_pl;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_time[mem_waddr] <= ta_q;
			mem_data[mem_waddr] <= ev_q;
		end
		rd_time_q <= mem_time[cur_d];
		rd_data_q <= mem_data[cur_d];
	end

endmodule

[tb/timestamped_event_history_ring_top_test.sv]
// Self-checking testbench for the timestamped event history ring top level.
module timestamped_event_history_ring_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RING_DEPTH = 32;
	localparam int unsigned DRAIN_CYCLES = RING_DEPTH + 8;
	localparam int unsigned STALL_CYCLES = 400;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam logic [tehr_pkg::APB_ADDR_W-1:0] INITIAL_VALUE_ADDR =
		tehr_pkg::APB_ADDR_W'(4 * tehr_pkg::REG_INITIAL_VALUE);

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [tehr_pkg::APB_ADDR_W-1:0] paddr;
	logic [tehr_pkg::APB_DATA_W-1:0] pwdata;
	logic [tehr_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	tehr_req_if req_ch();
	tehr_rsp_if rsp_ch();

	timestamped_event_history_ring_top #(.DEPTH(RING_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [tehr_pkg::DATA_W-1:0] ring_time [RING_DEPTH];
	logic [tehr_pkg::DATA_W-1:0] ring_data [RING_DEPTH];
	logic                        ring_valid [RING_DEPTH];
	int unsigned                 ring_head;

	tehr_pkg::out_item_t results_due [$];
	int unsigned send_idle_pct;
	int unsigned rcv_idle_pct;
	int unsigned stall_requests;
	int unsigned fail_count;
	int unsigned ops_sent;
	int unsigned results_checked;
	int unsigned overflow_flags;
	int unsigned longest_range;
	int unsigned empty_answers;

	always #4 clk = ~clk;

	function automatic int unsigned prev_slot(input int unsigned p);
		return (p == 0) ? RING_DEPTH - 1 : p - 1;
	endfunction

	function automatic int unsigned next_slot(input int unsigned p);
		return (p >= RING_DEPTH - 1) ? 0 : p + 1;
	endfunction

	function automatic tehr_pkg::in_item_t make_op(input logic [1:0] func,
			input logic [tehr_pkg::DATA_W-1:0] ta, input logic [tehr_pkg::DATA_W-1:0] tb,
			input logic [tehr_pkg::DATA_W-1:0] ev);
		tehr_pkg::in_item_t op;
		op.func = func;
		op.time_a = ta;
		op.time_b = tb;
		op.event_value = ev;
		return op;
	endfunction

	task automatic note_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic ring_reinit(input logic [tehr_pkg::DATA_W-1:0] value);
		for (int unsigned i = 0; i < RING_DEPTH; i++) begin
			ring_time[i] = '0;
			ring_data[i] = '0;
			ring_valid[i] = 1'b0;
		end
		ring_data[0] = value;
		ring_valid[0] = 1'b1;
		ring_head = 0;
	endtask

	task automatic ring_discard_newer(input logic [tehr_pkg::DATA_W-1:0] t);
		int unsigned p;
		for (int unsigned n = 0; n < RING_DEPTH; n++) begin
			p = ring_head;
			if (!(ring_valid[p] && ring_time[p] > t))
				break;
			ring_valid[p] = 1'b0;
			ring_time[p] = '0;
			ring_data[p] = '0;
			ring_head = prev_slot(p);
		end
	endtask

	task automatic post_expected(input logic [tehr_pkg::DATA_W-1:0] value, input logic hit,
			input logic last, input logic ovf);
		tehr_pkg::out_item_t r;
		r.result_value = value;
		r.hit = hit;
		r.last = last;
		r.overflow_warning = ovf;
		r.latest_time = ring_valid[ring_head] ? ring_time[ring_head] : '0;
		if (!hit)
			empty_answers++;
		results_due.insert(results_due.size(), r);
	endtask

	task automatic ring_apply(input tehr_pkg::in_item_t op);
		int unsigned p;
		int unsigned f;
		int unsigned start;
		int unsigned cnt;
		logic ovf;
		logic have_pending;
		logic [tehr_pkg::DATA_W-1:0] pending_value;
		case (op.func)
			tehr_pkg::FUNC_INSERT: begin
				ring_discard_newer(op.time_a);
				p = ring_head;
				if (!(ring_valid[p] && ring_time[p] == op.time_a))
					p = next_slot(p);
				ring_head = p;
				ovf = (p >= RING_DEPTH - 2);
				if (ovf)
					overflow_flags++;
				ring_data[p] = op.event_value;
				ring_time[p] = op.time_a;
				ring_valid[p] = 1'b1;
				post_expected('0, 1'b0, 1'b1, ovf);
				empty_answers--;
			end
			tehr_pkg::FUNC_LOOKUP: begin
				start = ring_head;
				f = start;
				for (int unsigned n = 0; n < RING_DEPTH; n++) begin
					if (!(ring_valid[f] && op.time_a < ring_time[f]))
						break;
					f = prev_slot(f);
					if (f == start) begin
						f = 0;
						break;
					end
				end
				if (!ring_valid[f])
					f = next_slot(f);
				post_expected(ring_data[f], ring_valid[f], 1'b1, 1'b0);
			end
			tehr_pkg::FUNC_RANGE: begin
				f = ring_head;
				cnt = 0;
				have_pending = 1'b0;
				pending_value = '0;
				for (int unsigned n = 0; n < RING_DEPTH; n++) begin
					if (!(ring_valid[f] && ring_time[f] != 0 && op.time_a <= ring_time[f]))
						break;
					if (ring_time[f] <= op.time_b && cnt < tehr_pkg::MAX_RESULTS) begin
						if (have_pending)
							post_expected(pending_value, 1'b1, 1'b0, 1'b0);
						pending_value = ring_data[f];
						have_pending = 1'b1;
						cnt++;
					end
					f = prev_slot(f);
				end
				if (have_pending)
					post_expected(pending_value, 1'b1, 1'b1, 1'b0);
				else
					post_expected('0, 1'b0, 1'b1, 1'b0);
				if (cnt > longest_range)
					longest_range = cnt;
			end
			default: begin
				ring_discard_newer(op.time_a);
				post_expected(ring_data[ring_head], ring_valid[ring_head], 1'b1, 1'b0);
			end
		endcase
	endtask

	task automatic send_op(input tehr_pkg::in_item_t op);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= op;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		ops_sent++;
		ring_apply(op);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_initial_value(input logic [tehr_pkg::DATA_W-1:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= INITIAL_VALUE_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		ring_reinit(value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value)
			note_mismatch($sformatf("initial_value read back %h, expected %h", prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_directed();
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, '0, '0, '0));
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, '1, '1, '1));
		send_op(make_op(tehr_pkg::FUNC_RANGE, '0, '1, '0));
		send_op(make_op(tehr_pkg::FUNC_ROLLBACK, '1, '0, '0));
		send_op(make_op(tehr_pkg::FUNC_INSERT, 32'd10, '0, 32'hAAAA_5555));
		send_op(make_op(tehr_pkg::FUNC_INSERT, 32'd20, '0, 32'hFFFF_FFFF));
		send_op(make_op(tehr_pkg::FUNC_INSERT, 32'd30, '0, 32'h0000_0000));
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, 32'd25, '0, '0));
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, 32'd5, '0, '0));
		send_op(make_op(tehr_pkg::FUNC_RANGE, 32'd15, 32'd30, '0));
		send_op(make_op(tehr_pkg::FUNC_RANGE, 32'd30, 32'd10, '0));
		send_op(make_op(tehr_pkg::FUNC_INSERT, 32'd20, '0, 32'h5555_AAAA));
		send_op(make_op(tehr_pkg::FUNC_INSERT, 32'd0, '0, 32'h0F0F_0F0F));
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, 32'd0, '0, '0));
		send_op(make_op(tehr_pkg::FUNC_INSERT, '1, '0, 32'h1234_5678));
		send_op(make_op(tehr_pkg::FUNC_RANGE, '0, '1, '0));
		send_op(make_op(tehr_pkg::FUNC_ROLLBACK, 32'd7, '0, '0));
		send_op(make_op(tehr_pkg::FUNC_INSERT, 32'd5, '0, 32'h8000_0001));
		send_op(make_op(tehr_pkg::FUNC_INSERT, 32'd1, '0, 32'h7FFF_FFFE));
		send_op(make_op(tehr_pkg::FUNC_ROLLBACK, 32'd0, '0, '0));
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, '1, '0, '0));
	endtask

	task automatic test_history_random(input int unsigned n_ops);
		tehr_pkg::in_item_t op;
		logic [tehr_pkg::DATA_W-1:0] cursor;
		int unsigned roll;
		cursor = $urandom_range(200, 2000);
		repeat (n_ops) begin
			roll = $urandom_range(99);
			op = make_op(tehr_pkg::FUNC_INSERT, cursor, $urandom(), $urandom());
			if (roll < 10) begin
				op.func = 2'($urandom_range(3));
				op.time_a = $urandom();
			end else if (roll < 42) begin
				cursor += $urandom_range(1, 60);
				op.time_a = cursor;
			end else if (roll < 50) begin
				op.time_a = cursor - $urandom_range(0, 80);
				cursor = op.time_a;
			end else if (roll < 68) begin
				op.func = tehr_pkg::FUNC_LOOKUP;
				op.time_a = cursor - $urandom_range(0, 500);
			end else if (roll < 90) begin
				op.func = tehr_pkg::FUNC_RANGE;
				op.time_a = cursor - $urandom_range(0, 400);
				op.time_b = op.time_a + $urandom_range(0, 400);
			end else begin
				op.func = tehr_pkg::FUNC_ROLLBACK;
				op.time_a = cursor - $urandom_range(0, 120);
				cursor = op.time_a;
			end
			send_op(op);
		end
	endtask

	task automatic test_full_ring();
		logic [tehr_pkg::DATA_W-1:0] t;
		logic [tehr_pkg::DATA_W-1:0] first_t;
		t = $urandom_range(1, 100);
		first_t = t;
		repeat (RING_DEPTH + 4) begin
			send_op(make_op(tehr_pkg::FUNC_INSERT, t, $urandom(), $urandom()));
			t += $urandom_range(1, 1000);
		end
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, '0, $urandom(), $urandom()));
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, $urandom_range(first_t, t), $urandom(),
			$urandom()));
		send_op(make_op(tehr_pkg::FUNC_RANGE, '0, '1, $urandom()));
		send_op(make_op(tehr_pkg::FUNC_RANGE, $urandom_range(first_t, t), t, $urandom()));
		send_op(make_op(tehr_pkg::FUNC_ROLLBACK, '0, $urandom(), $urandom()));
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, $urandom(), $urandom(), $urandom()));
		send_op(make_op(tehr_pkg::FUNC_RANGE, '0, '1, $urandom()));
		send_op(make_op(tehr_pkg::FUNC_ROLLBACK, '1, $urandom(), $urandom()));
		send_op(make_op(tehr_pkg::FUNC_INSERT, $urandom(), $urandom(), $urandom()));
		send_op(make_op(tehr_pkg::FUNC_LOOKUP, '1, $urandom(), $urandom()));
	endtask

	task automatic test_backpressure();
		logic [tehr_pkg::DATA_W-1:0] t;
		t = $urandom_range(1, 50);
		repeat (6) begin
			send_op(make_op(tehr_pkg::FUNC_INSERT, t, $urandom(), $urandom()));
			t += $urandom_range(1, 50);
		end
		stall_requests++;
		send_op(make_op(tehr_pkg::FUNC_RANGE, '0, '1, $urandom()));
		repeat (6)
			send_op(make_op(tehr_pkg::FUNC_LOOKUP, $urandom_range(0, t), $urandom(),
				$urandom()));
		send_op(make_op(tehr_pkg::FUNC_ROLLBACK, t - $urandom_range(0, 100), $urandom(),
			$urandom()));
	endtask

	initial begin
		int unsigned hold_left;
		int unsigned stall_seen;
		hold_left = 0;
		stall_seen = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_requests != stall_seen) begin
				stall_seen = stall_requests;
				hold_left = STALL_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		tehr_pkg::out_item_t want;
		tehr_pkg::out_item_t got;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.data;
			results_checked++;
			if (results_due.size() == 0) begin
				note_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = results_due.pop_front();
				if (got.result_value !== want.result_value || got.hit !== want.hit
						|| got.last !== want.last
						|| got.overflow_warning !== want.overflow_warning
						|| got.latest_time !== want.latest_time)
					note_mismatch($sformatf(
						"value %h/%h hit %b/%b last %b/%b ovf %b/%b latest %h/%h (exp/act)",
						want.result_value, got.result_value, want.hit, got.hit,
						want.last, got.last, want.overflow_warning, got.overflow_warning,
						want.latest_time, got.latest_time));
			end
		end
	end

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
					|| (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Watchdog expired with %0d results outstanding", results_due.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stall_requests = 0;
		fail_count = 0;
		ops_sent = 0;
		results_checked = 0;
		overflow_flags = 0;
		longest_range = 0;
		empty_answers = 0;
		send_idle_pct = 26;
		rcv_idle_pct = 87;
		ring_reinit('0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_initial_value($urandom());
		test_history_random(25);

		send_idle_pct = 87;
		rcv_idle_pct = 26;
		set_initial_value('1);
		test_full_ring();

		send_idle_pct = 0;
		rcv_idle_pct = 0;
		set_initial_value('0);
		test_backpressure();
		test_history_random(25);

		wait_drained();
		$display("Covered %0d operations and %0d result transactions across four initial values.",
			ops_sent, results_checked);
		$display("Longest range answer %0d, overflow flags %0d, empty or invalid answers %0d.",
			longest_range, overflow_flags, empty_answers);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches in total", fail_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
